// File: design/ssvm_pkg.sv
// Package for the saturating stereo voice mixer.
// Holds payload types, format codes, widths and control structs; no dependencies.
`default_nettype none
package ssvm_pkg;

   localparam int SampleWidth  = 16;
   localparam int GainWidth    = 16;
   localparam int MasterWidth  = 16;
   localparam int HalfWidth    = SampleWidth + 1;
   localparam int ProdWidth    = HalfWidth + MasterWidth;
   localparam int FracShift    = 12;
   localparam int QuotWidth    = ProdWidth - FracShift;
   localparam int ContribWidth = QuotWidth + 1;
   localparam int StepCount    = 16;
   localparam int CountWidth   = $clog2(StepCount);

   localparam logic [MasterWidth-1:0] MASTER_RESET = 16'd3277;

   localparam logic [1:0] FMT_MONO   = 2'd0;
   localparam logic [1:0] FMT_STEREO = 2'd1;
   localparam logic [1:0] FMT_U8     = 2'd2;
   localparam logic [1:0] FMT_SILENT = 2'd3;

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic [1:0]                    format_type;
   typedef logic [GainWidth-1:0]          gain_type;
   typedef logic [MasterWidth-1:0]        master_type;
   typedef logic [ProdWidth-1:0]          prod_type;

   typedef struct packed {
      sample_type sample_first;
      sample_type sample_second;
      format_type sample_format;
      gain_type   gain_left;
      gain_type   gain_right;
      logic       last_voice;
   } req_type;

   typedef struct packed {
      sample_type mix_left;
      sample_type mix_right;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step_a;
      logic step_b;
      logic commit;
      logic clear;
   } ctrl_type;

endpackage
`default_nettype wire

// File: design/ssvm_chan_if.sv
// Valid/ready channel interface used for request, response and register write ports.
// Payload type is a parameter; takes its types from ssvm_pkg at instantiation.
`default_nettype none
interface ssvm_chan_if #(parameter type payload_type = logic [0:0]) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/ssvm_front.sv
// Sample decode and bit-serial magnitude x master volume multiplier.
// Depends on ssvm_pkg; stepped by the controller in the top level.
`default_nettype none
module ssvm_front (
   input  wire logic                 clock,
   input  wire ssvm_pkg::ctrl_type   ctrl,
   input  wire ssvm_pkg::sample_type sample_first,
   input  wire ssvm_pkg::sample_type sample_second,
   input  wire ssvm_pkg::format_type sample_format,
   input  wire ssvm_pkg::master_type master,
   output ssvm_pkg::prod_type        product,
   output logic                      negative
);

   localparam int HW = ssvm_pkg::HalfWidth;
   localparam int MW = ssvm_pkg::MasterWidth;

   logic signed [HW-1:0] half;
   logic [HW-1:0]        mag;
   logic [HW-1:0]        mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [HW-1:0]        hi_ff, hi_in;
   logic [MW-1:0]        lo_ff, lo_in;
   logic [HW:0]          sum;

   always_comb begin
      unique case (sample_format)
         ssvm_pkg::FMT_MONO: begin
            half = {sample_first, 1'b0};
         end
         ssvm_pkg::FMT_STEREO: begin
            half = {sample_first[15], sample_first} + {sample_second[15], sample_second};
         end
         ssvm_pkg::FMT_U8: begin
            half = {~sample_first[7], sample_first[6:0], 9'd0};
         end
         default: begin
            half = '0;
         end
      endcase
      mag = half[HW-1] ? (~half + HW'(1)) : half;
   end

   always_comb begin
      sum    = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mag_ff} : '0);
      mag_in = mag_ff;
      neg_in = neg_ff;
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      if (ctrl.load) begin
         mag_in = mag;
         neg_in = half[HW-1];
         hi_in  = '0;
         lo_in  = master;
      end else if (ctrl.step_a) begin
         {hi_in, lo_in} = {sum, lo_ff[MW-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
   end

   assign product  = {hi_ff, lo_ff};
   assign negative = neg_ff;

endmodule
`default_nettype wire

// File: design/ssvm_lane.sv
// One output channel: bit-serial gain multiplier, truncation and saturating accumulator.
// Depends on ssvm_pkg; takes the product of ssvm_front.
`default_nettype none
module ssvm_lane (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ssvm_pkg::ctrl_type   ctrl,
   input  wire ssvm_pkg::gain_type   gain,
   input  wire ssvm_pkg::prod_type   product,
   input  wire logic                 negative,
   output ssvm_pkg::sample_type      mix_sum
);

   localparam int PW = ssvm_pkg::ProdWidth;
   localparam int GW = ssvm_pkg::GainWidth;
   localparam int QW = ssvm_pkg::QuotWidth;
   localparam int CW = ssvm_pkg::ContribWidth;
   localparam int SW = ssvm_pkg::SampleWidth;

   logic [PW-1:0]        p_ff, p_in;
   logic [GW-1:0]        g_ff, g_in;
   ssvm_pkg::sample_type acc_ff, acc_in;
   logic [PW:0]          step_sum;
   logic [QW-1:0]        quot;
   logic signed [CW-1:0] contrib;
   logic signed [CW:0]   total;

   always_comb begin
      step_sum = {1'b0, p_ff} + (g_ff[0] ? {1'b0, product} : '0);
      p_in     = p_ff;
      g_in     = g_ff;
      if (ctrl.load) begin
         p_in = '0;
         g_in = gain;
      end else if (ctrl.step_b) begin
         p_in = step_sum[PW:1];
         g_in = {1'b0, g_ff[GW-1:1]};
      end
   end

   always_comb begin
      quot    = p_ff[PW-1:ssvm_pkg::FracShift];
      contrib = negative ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      total   = $signed({{(CW-SW+1){acc_ff[SW-1]}}, acc_ff}) + $signed({contrib[CW-1], contrib});
      if (total[CW:SW-1] == '0 || total[CW:SW-1] == '1) begin
         mix_sum = total[SW-1:0];
      end else if (total[CW]) begin
         mix_sum = {1'b1, {(SW-1){1'b0}}};
      end else begin
         mix_sum = {1'b0, {(SW-1){1'b1}}};
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.commit) begin
         acc_in = mix_sum;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      g_ff <= g_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule
`default_nettype wire

// File: design/saturating_stereo_voice_mixer_top.sv
// Saturating stereo voice mixer: one voice beat in, one frame beat out per last voice.
// Each voice runs 16 steps of the serial magnitude x master multiplier, 16 steps of
// the two serial gain multipliers and one add before the next voice is accepted. The
// add of a last voice waits for any pending frame beat; its frame goes to the output
// register, held until taken. Synchronous reset clears both accumulators, drops any
// pending result and sets master volume to 3277. Depends on ssvm_pkg, ssvm_chan_if.
`default_nettype none
module saturating_stereo_voice_mixer_top (
   input  wire logic    clock,
   input  wire logic    reset,
   ssvm_chan_if.sink    req_ch,
   ssvm_chan_if.source  rsp_ch,
   ssvm_chan_if.sink    csr_ch
);

   localparam int CNW = ssvm_pkg::CountWidth;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MULA = 2'd1;
   localparam logic [1:0] ST_MULB = 2'd2;
   localparam logic [1:0] ST_ACC  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [CNW-1:0]       cnt_ff, cnt_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ssvm_pkg::rsp_type    rsp_data_ff, rsp_data_in;
   ssvm_pkg::master_type master_ff, master_in;
   ssvm_pkg::ctrl_type   ctrl;
   ssvm_pkg::req_type    req;
   ssvm_pkg::prod_type   product;
   logic                 negative;
   ssvm_pkg::sample_type left_sum, right_sum;
   logic                 cnt_done;

   assign req          = req_ch.data;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;
   assign cnt_done     = (cnt_ff == CNW'(ssvm_pkg::StepCount - 1));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      master_in    = (csr_ch.valid && csr_ch.ready) ? csr_ch.data : master_ff;
      ctrl         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               ctrl.load = 1'b1;
               last_in   = req.last_voice;
               cnt_in    = '0;
               state_in  = ST_MULA;
            end
         end
         ST_MULA: begin
            ctrl.step_a = 1'b1;
            cnt_in      = cnt_ff + CNW'(1);
            if (cnt_done) begin
               state_in = ST_MULB;
            end
         end
         ST_MULB: begin
            ctrl.step_b = 1'b1;
            cnt_in      = cnt_ff + CNW'(1);
            if (cnt_done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (!last_ff) begin
               ctrl.commit = 1'b1;
               state_in    = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ch.ready) begin
               ctrl.clear   = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{mix_left: left_sum, mix_right: right_sum};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         master_ff    <= ssvm_pkg::MASTER_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         master_ff    <= master_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   ssvm_front u_front (
      .clock         (clock),
      .ctrl          (ctrl),
      .sample_first  (req.sample_first),
      .sample_second (req.sample_second),
      .sample_format (req.sample_format),
      .master        (master_ff),
      .product       (product),
      .negative      (negative)
   );

   ssvm_lane u_lane_left (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .gain     (req.gain_left),
      .product  (product),
      .negative (negative),
      .mix_sum  (left_sum)
   );

   ssvm_lane u_lane_right (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .gain     (req.gain_right),
      .product  (product),
      .negative (negative),
      .mix_sum  (right_sum)
   );

`ifndef SYNTHESIS
   a_rsp_from_acc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_ACC && $past(last_ff)))
      else $error("frame beat raised outside the accumulate step of a last voice");

   a_phase_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULA && cnt_done) |=> (state_ff == ST_MULB && cnt_ff == '0))
      else $error("gain phase did not start with a cleared step count");

   a_ctrl_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.load, ctrl.step_a, ctrl.step_b, ctrl.commit, ctrl.clear}))
      else $error("more than one datapath command in a cycle");

   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending frame beat overwritten");
`endif

endmodule
`default_nettype wire

// File: dv/tb_saturating_stereo_voice_mixer_top.sv
// Testbench for saturating_stereo_voice_mixer_top: drives voice beats and master volume
// writes, predicts each mixed frame in a scoreboard class and checks every frame beat.
// Depends on ssvm_pkg and ssvm_chan_if from the design folder.
`default_nettype none
module tb_saturating_stereo_voice_mixer_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ssvm_pkg::*;

   localparam int SettleCycles = 40;

   class mix_scoreboard;
      master_type master;
      int         acc_left;
      int         acc_right;
      rsp_type    pending_frames[$];
      int         errors;

      function new();
         master    = MASTER_RESET;
         acc_left  = 0;
         acc_right = 0;
         errors    = 0;
      endfunction

      function int scale_voice(int half, gain_type gain);
         bit [63:0] mag;
         bit [63:0] prod;
         int        q;
         mag  = (half < 0) ? 64'(-half) : 64'(half);
         prod = mag * 64'(gain) * 64'(master);
         q    = int'(prod >> 28);
         return (half < 0) ? -q : q;
      endfunction

      function int sat_add(int acc, int add);
         int s;
         s = acc + add;
         if (s > 32767) s = 32767;
         if (s < -32768) s = -32768;
         return s;
      endfunction

      function void note_voice(req_type v);
         int      half;
         rsp_type frame;
         case (v.sample_format)
            FMT_MONO:   half = 2 * int'(v.sample_first);
            FMT_STEREO: half = int'(v.sample_first) + int'(v.sample_second);
            FMT_U8:     half = 2 * ((int'(v.sample_first[7:0]) - 128) * 256);
            default:    half = 0;
         endcase
         acc_left  = sat_add(acc_left, scale_voice(half, v.gain_left));
         acc_right = sat_add(acc_right, scale_voice(half, v.gain_right));
         if (v.last_voice) begin
            frame.mix_left  = acc_left[15:0];
            frame.mix_right = acc_right[15:0];
            pending_frames.push_back(frame);
            acc_left  = 0;
            acc_right = 0;
         end
      endfunction

      function void check_frame(rsp_type got);
         rsp_type want;
         if (pending_frames.size() == 0) begin
            $display("%0t: unexpected frame beat, actual left %0d right %0d",
                     $time, got.mix_left, got.mix_right);
            errors++;
            return;
         end
         want = pending_frames.pop_front();
         if (got.mix_left !== want.mix_left) begin
            $display("%0t: mix_left mismatch, expected %0d actual %0d",
                     $time, want.mix_left, got.mix_left);
            errors++;
         end
         if (got.mix_right !== want.mix_right) begin
            $display("%0t: mix_right mismatch, expected %0d actual %0d",
                     $time, want.mix_right, got.mix_right);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   src_idle_pct;
   int   snk_idle_pct;
   mix_scoreboard sb;

   ssvm_chan_if #(.payload_type(req_type))    req_ch ();
   ssvm_chan_if #(.payload_type(rsp_type))    rsp_ch ();
   ssvm_chan_if #(.payload_type(master_type)) csr_ch ();

   saturating_stereo_voice_mixer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // frame beat sink: random stalls, check on every accepted beat
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_frame(rsp_ch.data);
         rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
   end

   function automatic req_type voice(sample_type a, sample_type b, format_type f,
                                     gain_type gl, gain_type gr, logic last);
      req_type v;
      v.sample_first  = a;
      v.sample_second = b;
      v.sample_format = f;
      v.gain_left     = gl;
      v.gain_right    = gr;
      v.last_voice    = last;
      return v;
   endfunction

   function automatic sample_type rand_sample();
      case ($urandom_range(9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return sample_type'($urandom_range(0, 15)) - 16'sd8;
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic gain_type rand_gain();
      case ($urandom_range(7))
         0:       return 16'd0;
         1:       return 16'd32768;
         2:       return gain_type'($urandom_range(32769, 65535));
         default: return gain_type'($urandom_range(0, 32768));
      endcase
   endfunction

   task automatic send_voice(input req_type v);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_voice(v);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.pending_frames.size() != 0) @(posedge clock);
   endtask

   task automatic wait_idle();
      wait_drained();
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_master(input master_type value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      sb.master = value;
   endtask

   task automatic run_random(input int n_voices);
      int sent;
      int len;
      sent = 0;
      while (sent < n_voices) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
         for (int i = 0; i < len; i++)
            send_voice(voice(rand_sample(), rand_sample(), format_type'($urandom_range(3)),
                             rand_gain(), rand_gain(), i == len - 1));
         sent += len;
         if ($urandom_range(39) == 0) wait_drained();
      end
   endtask

   initial begin
      sb = new();
      src_idle_pct = 17;
      snk_idle_pct = 50;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.data  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset master volume
      send_voice(voice(16'sh7FFF, 16'sh0000, FMT_MONO,   16'd65535, 16'd0,     1'b1));
      send_voice(voice(16'sh8000, 16'sh7FFF, FMT_MONO,   16'd0,     16'd65535, 1'b1));
      send_voice(voice(16'sh7FFF, 16'sh7FFF, FMT_STEREO, 16'd32768, 16'd32768, 1'b1));
      send_voice(voice(16'sh8000, 16'sh8000, FMT_STEREO, 16'd65535, 16'd65535, 1'b1));
      send_voice(voice(16'sh7FFF, 16'sh8000, FMT_STEREO, 16'd32768, 16'd32768, 1'b1));
      send_voice(voice(16'shFF00, 16'sh1234, FMT_U8,     16'd32768, 16'd65535, 1'b0));
      send_voice(voice(16'sh00FF, 16'sh8000, FMT_U8,     16'd32768, 16'd32768, 1'b0));
      send_voice(voice(16'sh5A80, 16'sh7FFF, FMT_U8,     16'd65535, 16'd65535, 1'b1));
      send_voice(voice(16'sh8000, 16'sh7FFF, FMT_SILENT, 16'd65535, 16'd65535, 1'b1));
      send_voice(voice(16'sh0001, 16'sh0000, FMT_MONO,   16'd1,     16'd1,     1'b1));
      send_voice(voice(-16'sd3,   16'sh0000, FMT_MONO,   16'd32768, 16'd12345, 1'b1));
      wait_idle();

      // saturation in both directions, mid-frame
      write_master(16'd65535);
      repeat (3) send_voice(voice(16'sh7FFF, 16'sh0, FMT_MONO, 16'd65535, 16'd65535, 1'b0));
      send_voice(voice(-16'sd20000, 16'sh0, FMT_MONO, 16'd65535, 16'd32768, 1'b1));
      repeat (2) send_voice(voice(16'sh8000, 16'sh0, FMT_MONO, 16'd65535, 16'd65535, 1'b0));
      send_voice(voice(16'sh00FF, 16'sh0, FMT_U8, 16'd65535, 16'd65535, 1'b1));
      send_voice(voice(16'sh7FFF, 16'sh7FFF, FMT_SILENT, 16'd0, 16'd0, 1'b1));
      wait_idle();
      write_master(16'd0);
      send_voice(voice(16'sh7FFF, 16'sh0, FMT_MONO, 16'd65535, 16'd65535, 1'b1));
      wait_idle();

      // random frames over several master settings and idle mixes
      write_master(16'd4096);
      run_random(225);
      wait_idle();

      src_idle_pct = 50;
      snk_idle_pct = 17;
      write_master(master_type'($urandom));
      run_random(225);
      wait_idle();

      src_idle_pct = 0;
      snk_idle_pct = 0;
      write_master(16'd65535);
      run_random(225);
      wait_idle();

      write_master(master_type'($urandom_range(0, 8191)));
      run_random(225);
      send_voice(voice(rand_sample(), rand_sample(), FMT_MONO, rand_gain(), rand_gain(), 1'b1));
      wait_idle();

      if (sb.errors == 0 && sb.pending_frames.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: files.f
design/ssvm_pkg.sv
design/ssvm_chan_if.sv
design/ssvm_front.sv
design/ssvm_lane.sv
design/saturating_stereo_voice_mixer_top.sv
dv/tb_saturating_stereo_voice_mixer_top.sv
